### sv/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies; included by the files that hold concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### sv/icmp_pkg.sv
// shared types, constants and the ones-complement adder for the icmp echo parser
// no dependencies; imported by icmp_echo_parser, icmp_chk and tb_top
`default_nettype none

package icmp_pkg;

    // width of the saturating byte counter
    localparam int LEN_BITS = 16;

    // output stream payload width: 60 bits of fields padded to whole bytes
    localparam int M_TDATA_W = 64;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_BAD_SUM  = 3'd2,
        ST_SHORT_IP = 3'd3,
        ST_UNKNOWN  = 3'd4
    } t_status;

    // icmp echo type codes
    localparam logic [7:0] V4_REQUEST = 8'd8;
    localparam logic [7:0] V4_REPLY   = 8'd0;
    localparam logic [7:0] V6_REQUEST = 8'd128;
    localparam logic [7:0] V6_REPLY   = 8'd129;

    // ip_mode register values
    localparam logic MODE_V4 = 1'b0;

    localparam logic [15:0] SUM_GOOD = 16'hffff;

    // 16-bit ones-complement add with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] acc, input logic [15:0] word);
        logic [16:0] s;
        s = {1'b0, acc} + {1'b0, word};
        return s[16] ? (s[15:0] + 16'd1) : s[15:0];
    endfunction

endpackage

`default_nettype wire

### sv/icmp_echo_parser.sv
// icmp echo parser top level: header strip, checksum, echo field capture
// depends on icmp_pkg
`default_nettype none

// usage
// - input stream s_axis_*: one packet byte per request in tdata, tlast on the
//   final byte of the packet; a request is taken when tvalid and tready are high
// - output stream m_axis_*: one request per payload byte and one for the last
//   byte; tuser flags a payload byte, tlast marks the packet status request
// - config: i_cfg_we writes i_cfg_wdata into ip_mode (0 ipv4, 1 ipv6); write it
//   only while no packet is in flight
// - a consumed byte moves from the input register to the result register;
//   its request is on m_axis from then on until it is taken
// - throughput: one byte per cycle unless the receiver stalls, set by the
//   per-byte checksum add and offset compares in one stage between registers
// - bytes in the ipv4 header and icmp header bytes 0..7 (other than the last
//   byte) produce no output request and leave the result register free
// - a stalled receiver holds the result register; once the input register
//   holds a byte with a request, s_axis_tready drops until the result is taken
// - reset (synchronous, active low) empties both registers, sets ipv4 mode
//   and clears all per-packet state; the same state clears after each last byte
module icmp_echo_parser (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // config
    input  wire                             i_cfg_we,
    input  wire                             i_cfg_wdata,
    // input stream
    input  wire                             s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire  [7:0]                      s_axis_tdata,   // [7:0] data_byte
    input  wire                             s_axis_tlast,   // last_byte
    // output stream
    output logic                            m_axis_tvalid,
    input  wire                             m_axis_tready,
    // [7:0] payload_byte, [10:8] status, [11] is_reply, [27:12] ident,
    // [43:28] seq_number, [59:44] payload_length, [63:60] zero
    output logic [icmp_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    output logic                            m_axis_tlast,   // done_res
    output logic                            m_axis_tuser    // payload_valid
);
    import icmp_pkg::*;

    // config register
    logic r_ip_mode;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // per-packet state
    logic [LEN_BITS-1:0] r_byte_count, n_byte_count;
    logic [5:0]          r_hdr_len,    n_hdr_len;
    logic [15:0]         r_sum_acc,    n_sum_acc;
    logic [7:0]          r_high_byte,  n_high_byte;
    logic                r_half_pend,  n_half_pend;
    logic [7:0]          r_type_byte,  n_type_byte;
    logic [15:0]         r_ident,      n_ident;
    logic [15:0]         r_seq,        n_seq;

    // result register
    logic                 r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data, n_out_data;
    logic                 r_out_last;
    logic                 r_out_pay;

    // per-byte working signals
    logic [5:0]          hlen;
    logic [LEN_BITS-1:0] hlen_ext;
    logic                in_icmp;
    logic [LEN_BITS-1:0] off;
    logic                pay;
    logic [15:0]         sum_word;
    logic [15:0]         fin_sum;
    logic [LEN_BITS-1:0] total;
    logic [LEN_BITS-1:0] rem;
    logic [LEN_BITS-1:0] pl;
    logic [15:0]         plen;
    t_status             status;
    logic                reply;
    logic [7:0]          req_code, rep_code;
    logic                produces;
    logic                out_free;
    logic                consume;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign produces      = pay || r_in_last;
    assign consume       = r_in_valid && (!produces || out_free);
    assign s_axis_tready = !r_in_valid || consume;

    always_comb begin
        // header length is fixed by the first byte of the packet
        if (r_byte_count == '0) begin
            hlen = (r_ip_mode == MODE_V4) ? {r_in_byte[3:0], 2'b00} : 6'd0;
        end else begin
            hlen = r_hdr_len;
        end
        hlen_ext = LEN_BITS'(hlen);
        in_icmp  = (r_byte_count >= hlen_ext);
        off      = r_byte_count - hlen_ext;
        pay      = in_icmp && (off >= LEN_BITS'(8));

        // capture echo header fields
        n_type_byte = r_type_byte;
        n_ident     = r_ident;
        n_seq       = r_seq;
        if (in_icmp) begin
            case (off)
                LEN_BITS'(0): n_type_byte   = r_in_byte;
                LEN_BITS'(4): n_ident[15:8] = r_in_byte;
                LEN_BITS'(5): n_ident[7:0]  = r_in_byte;
                LEN_BITS'(6): n_seq[15:8]   = r_in_byte;
                LEN_BITS'(7): n_seq[7:0]    = r_in_byte;
                default: ;
            endcase
        end

        // checksum: pair bytes into big-endian words; the folded sum with any
        // unpaired byte padded is what the last byte is checked against
        if (in_icmp) begin
            sum_word = r_half_pend ? {r_high_byte, r_in_byte} : {r_in_byte, 8'h00};
        end else begin
            sum_word = r_half_pend ? {r_high_byte, 8'h00} : 16'h0000;
        end
        fin_sum = oc_add(r_sum_acc, sum_word);

        n_sum_acc   = r_sum_acc;
        n_high_byte = r_high_byte;
        n_half_pend = r_half_pend;
        if (in_icmp) begin
            if (r_half_pend) begin
                n_sum_acc   = fin_sum;
                n_half_pend = 1'b0;
            end else begin
                n_high_byte = r_in_byte;
                n_half_pend = 1'b1;
            end
        end

        // saturating byte count
        total = (r_byte_count == '1) ? r_byte_count : (r_byte_count + LEN_BITS'(1));

        // packet status on the last byte
        req_code = (r_ip_mode == MODE_V4) ? V4_REQUEST : V6_REQUEST;
        rep_code = (r_ip_mode == MODE_V4) ? V4_REPLY   : V6_REPLY;
        rem      = total - hlen_ext;
        pl       = rem - LEN_BITS'(8);
        if (LEN_BITS > 16 && (32'(pl) >> 16) != 32'd0) begin
            plen = 16'hffff;
        end else begin
            plen = 16'(pl);
        end
        reply  = 1'b0;
        status = ST_OK;
        if (total < hlen_ext) begin
            status = ST_SHORT_IP;
        end else if (rem < LEN_BITS'(8)) begin
            status = ST_SHORT;
        end else if (r_ip_mode == MODE_V4 && fin_sum != SUM_GOOD) begin
            status = ST_BAD_SUM;
        end else if (n_type_byte == req_code) begin
            reply = 1'b0;
        end else if (n_type_byte == rep_code) begin
            reply = 1'b1;
        end else begin
            status = ST_UNKNOWN;
        end

        // result word; fields other than the payload byte only on the last byte
        n_out_data = '0;
        if (pay) begin
            n_out_data[7:0] = r_in_byte;
        end
        if (r_in_last) begin
            n_out_data[10:8] = status;
            if (status == ST_OK) begin
                n_out_data[11]    = reply;
                n_out_data[27:12] = n_ident;
                n_out_data[43:28] = n_seq;
                n_out_data[59:44] = plen;
            end
        end

        n_byte_count = total;
        n_hdr_len    = hlen;
        // all per-packet state returns to zero after the last byte
        if (r_in_last) begin
            n_byte_count = '0;
            n_hdr_len    = '0;
            n_sum_acc    = '0;
            n_high_byte  = '0;
            n_half_pend  = 1'b0;
            n_type_byte  = '0;
            n_ident      = '0;
            n_seq        = '0;
        end
    end

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ip_mode <= MODE_V4;
        end else if (i_cfg_we) begin
            r_ip_mode <= i_cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // per-packet state advances once per consumed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_hdr_len    <= '0;
            r_sum_acc    <= '0;
            r_high_byte  <= '0;
            r_half_pend  <= 1'b0;
            r_type_byte  <= '0;
            r_ident      <= '0;
            r_seq        <= '0;
        end else if (consume) begin
            r_byte_count <= n_byte_count;
            r_hdr_len    <= n_hdr_len;
            r_sum_acc    <= n_sum_acc;
            r_high_byte  <= n_high_byte;
            r_half_pend  <= n_half_pend;
            r_type_byte  <= n_type_byte;
            r_ident      <= n_ident;
            r_seq        <= n_seq;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= consume && produces;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && consume && produces) begin
            r_out_data <= n_out_data;
            r_out_last <= r_in_last;
            r_out_pay  <= pay;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_pay;

endmodule

`default_nettype wire

### sv/icmp_chk.sv
// port-level checker for icmp_echo_parser, attached by bind
// depends on icmp_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module icmp_chk (
    input wire                             i_clk,
    input wire                             i_rst_n,
    input wire                             m_axis_tvalid,
    input wire                             m_axis_tready,
    input wire [icmp_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input wire                             m_axis_tlast,
    input wire                             m_axis_tuser
);
    import icmp_pkg::*;

    // a stalled request stays and holds its payload
    `ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `ASSERT_NEXT(a_hold_data, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

    // payload byte is zero unless flagged as payload
    `ASSERT_IMPLY(a_pay_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[7:0] == 8'h00)

    // every output request carries payload or closes a packet
    `ASSERT_IMPLY(a_no_empty, i_clk, i_rst_n, m_axis_tvalid, m_axis_tuser || m_axis_tlast)

    // echo fields only on the last byte, and only on success
    `ASSERT_IMPLY(a_fail_clear, i_clk, i_rst_n, m_axis_tvalid && (!m_axis_tlast || m_axis_tdata[10:8] != ST_OK), m_axis_tdata[59:11] == '0)

endmodule

bind icmp_echo_parser icmp_chk u_icmp_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

### sim/tb_top.sv
// testbench for icmp_echo_parser: directed and random packets in both ip modes
// checks every output request against a byte-level parser model kept in this file
// depends on icmp_pkg and icmp_echo_parser
`timescale 1ns / 1ps

module tb_top;

    import icmp_pkg::*;

    // longest stretch with no request moving on either side before we give up
    localparam int STALL_LIMIT = 2000;
    // byte counter ceiling of the block
    localparam int COUNT_MAX   = (1 << LEN_BITS) - 1;

    // one expected output request
    typedef struct packed {
        logic        pay;
        logic [7:0]  pbyte;
        logic        done;
        t_status     st;
        logic        reply;
        logic [15:0] id;
        logic [15:0] sq;
        logic [15:0] plen;
    } echo_result_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic                i_cfg_wdata = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic                s_axis_tlast = 1'b0;    // last_byte
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // [7:0] payload_byte, [10:8] status, [11] is_reply, [27:12] ident,
    // [43:28] seq_number, [59:44] payload_length, [63:60] zero
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                m_axis_tlast;           // done_res
    logic                m_axis_tuser;           // payload_valid

    // packet under construction, sent byte by byte
    logic [7:0]   pkt_bytes[$];
    // expected output requests, oldest first
    echo_result_t pending_results[$];

    // parser model state, mirrors what the block holds per packet
    logic         cur_mode = MODE_V4;
    int           rx_count = 0;
    int           hdr_len = 0;
    logic [15:0]  sum_now = '0;
    logic [7:0]   held_byte = '0;
    logic         half_held = 1'b0;
    logic [7:0]   type_seen = '0;
    logic [15:0]  ident_seen = '0;
    logic [15:0]  seq_seen = '0;

    // run bookkeeping
    bit           jitter_on = 1'b0;
    int           mismatch_count = 0;
    int           results_checked = 0;
    int           pkt_count = 0;
    int           byte_total = 0;
    int           quiet_cycles = 0;

    icmp_echo_parser uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 4 ns clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ones-complement add with end-around carry
    function automatic logic [15:0] wrap_add(input logic [15:0] a, input logic [15:0] w);
        logic [16:0] t;
        t = {1'b0, a} + {1'b0, w};
        return t[15:0] + {15'd0, t[16]};
    endfunction

    // checksum over pkt_bytes from one index on, odd tail padded with a zero low byte
    function automatic logic [15:0] icmp_sum_from(input int from);
        logic [15:0] acc;
        int          i;
        acc = '0;
        for (i = from; i < pkt_bytes.size(); i += 2) begin
            acc = wrap_add(acc, {pkt_bytes[i], (i + 1 < pkt_bytes.size()) ? pkt_bytes[i + 1]
                                                                            : 8'h00});
        end
        return acc;
    endfunction

    // model of the parser for one accepted byte; queues the request it should produce
    task automatic parse_byte(input logic [7:0] b, input logic last);
        int           cnt;
        int           hl;
        int           total;
        int           pl;
        logic [15:0]  fin;
        logic [7:0]   req_code;
        logic [7:0]   rep_code;
        echo_result_t r;
        cnt = rx_count;
        r = '0;
        // header length is latched from the first byte, ipv6 never strips
        if (cnt == 0) begin
            hl = (cur_mode == MODE_V4) ? int'(b[3:0]) * 4 : 0;
            hdr_len = hl;
        end else begin
            hl = hdr_len;
        end
        if (cnt >= hl) begin
            case (cnt - hl)
                0: type_seen = b;
                4: ident_seen[15:8] = b;
                5: ident_seen[7:0] = b;
                6: seq_seen[15:8] = b;
                7: seq_seen[7:0] = b;
                default: ;
            endcase
            // bytes pair up into big-endian words for the checksum
            if (half_held) begin
                sum_now = wrap_add(sum_now, {held_byte, b});
                half_held = 1'b0;
            end else begin
                held_byte = b;
                half_held = 1'b1;
            end
            if (cnt - hl >= 8) begin
                r.pay = 1'b1;
                r.pbyte = b;
            end
        end
        // saturating byte count
        total = (cnt < COUNT_MAX) ? cnt + 1 : COUNT_MAX;
        rx_count = total;
        if (last) begin
            fin = half_held ? wrap_add(sum_now, {held_byte, 8'h00}) : sum_now;
            req_code = (cur_mode == MODE_V4) ? V4_REQUEST : V6_REQUEST;
            rep_code = (cur_mode == MODE_V4) ? V4_REPLY : V6_REPLY;
            r.done = 1'b1;
            if (total < hl) begin
                r.st = ST_SHORT_IP;
            end else if (total - hl < 8) begin
                r.st = ST_SHORT;
            end else if (cur_mode == MODE_V4 && fin != SUM_GOOD) begin
                r.st = ST_BAD_SUM;
            end else if (type_seen == req_code || type_seen == rep_code) begin
                r.reply = (type_seen == rep_code);
                r.id = ident_seen;
                r.sq = seq_seen;
                pl = total - hl - 8;
                r.plen = (pl > 65535) ? 16'hffff : pl[15:0];
            end else begin
                r.st = ST_UNKNOWN;
            end
            // per-packet state starts over after the last byte
            rx_count = 0;
            hdr_len = 0;
            sum_now = '0;
            held_byte = '0;
            half_held = 1'b0;
            type_seen = '0;
            ident_seen = '0;
            seq_seen = '0;
        end
        if (r.pay || r.done) pending_results.push_back(r);
    endtask

    // compare one output request with the oldest expectation
    task automatic check_echo_result();
        echo_result_t got;
        echo_result_t want;
        bit           bad;
        got.pay   = m_axis_tuser;
        got.pbyte = m_axis_tdata[7:0];
        got.done  = m_axis_tlast;
        got.st    = t_status'(m_axis_tdata[10:8]);
        got.reply = m_axis_tdata[11];
        got.id    = m_axis_tdata[27:12];
        got.sq    = m_axis_tdata[43:28];
        got.plen  = m_axis_tdata[59:44];
        results_checked++;
        if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected output request: pv=%0b pb=%02h done=%0b st=%0d",
                         got.pay, got.pbyte, got.done, got.st);
        end else begin
            want = pending_results.pop_front();
            bad = (got.pay !== want.pay) || (got.pbyte !== want.pbyte) ||
                  (got.done !== want.done) || (got.st !== want.st) ||
                  (got.reply !== want.reply) || (got.id !== want.id) ||
                  (got.sq !== want.sq) || (got.plen !== want.plen);
            if (bad) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("exp %0d: pv=%0b pb=%02h dn=%0b st=%0d rp=%0b id=%04h sq=%04h ln=%0d",
                             mismatch_count, want.pay, want.pbyte, want.done, want.st,
                             want.reply, want.id, want.sq, want.plen);
                    $display("got %0d: pv=%0b pb=%02h dn=%0b st=%0d rp=%0b id=%04h sq=%04h ln=%0d",
                             mismatch_count, got.pay, got.pbyte, got.done, got.st,
                             got.reply, got.id, got.sq, got.plen);
                end
            end
        end
    endtask

    // both handshakes sampled at the edge, before any driver update lands
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) cur_mode = i_cfg_wdata;
            if (s_axis_tvalid && s_axis_tready) parse_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) check_echo_result();
        end
    end

    // watchdog on cycles where no request moves on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no request moved for %0d cycles", quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver back-pressure: random stall bursts while jitter is on
    initial begin
        forever begin
            if (jitter_on && $urandom_range(0, 9) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // present one byte and hold it until the block takes it
    task automatic send_byte(input logic [7:0] d, input logic l);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tlast  <= l;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // send pkt_bytes with tlast on the final byte, random sender gaps while jitter is on
    task automatic send_packet();
        int i;
        for (i = 0; i < pkt_bytes.size(); i++) begin
            if (jitter_on && $urandom_range(0, 9) == 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
        end
        pkt_count++;
        byte_total += pkt_bytes.size();
    endtask

    // build a packet: optional ipv4 header of ihl words, icmp echo header, payload;
    // in ipv4 the checksum is filled in, then spoiled when good_sum is clear
    task automatic make_packet(input bit v6, input logic [3:0] ihl, input logic [7:0] typ,
                               input int pay_len, input bit good_sum);
        int          i;
        int          icmp_at;
        logic [15:0] csum;
        pkt_bytes.delete();
        if (!v6 && ihl != 0) begin
            pkt_bytes.push_back({4'h4, ihl});
            for (i = 1; i < int'(ihl) * 4; i++) pkt_bytes.push_back(8'($urandom));
        end
        icmp_at = pkt_bytes.size();
        pkt_bytes.push_back(typ);
        pkt_bytes.push_back(8'($urandom));
        pkt_bytes.push_back(8'h00);
        pkt_bytes.push_back(8'h00);
        for (i = 0; i < 4 + pay_len; i++) pkt_bytes.push_back(8'($urandom));
        if (!v6) begin
            csum = ~icmp_sum_from(icmp_at);
            pkt_bytes[icmp_at + 2] = csum[15:8];
            pkt_bytes[icmp_at + 3] = csum[7:0];
            if (!good_sum) pkt_bytes[icmp_at + 2] ^= 8'h01 << $urandom_range(0, 7);
        end
    endtask

    task automatic truncate_packet(input int n);
        while (pkt_bytes.size() > n) void'(pkt_bytes.pop_back());
    endtask

    // write ip_mode once the block has drained; header bytes give no request,
    // so the task waits on past the last expected request to cover the pipeline
    task automatic set_ip_mode(input logic mode);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // ipv4 echo request and reply, widest header, header length of zero
    task automatic test_v4_echo();
        set_ip_mode(MODE_V4);
        make_packet(1'b0, 4'd5, V4_REQUEST, 3, 1'b1);
        send_packet();
        // ihl 15 gives the longest header, reply with no payload
        make_packet(1'b0, 4'd15, V4_REPLY, 0, 1'b1);
        send_packet();
        // first byte low nibble 0: it is the type byte as well
        make_packet(1'b0, 4'd0, V4_REPLY, 2, 1'b1);
        send_packet();
        // odd icmp length: final byte padded for the checksum
        make_packet(1'b0, 4'd5, V4_REQUEST, 5, 1'b1);
        send_packet();
    endtask

    // each ipv4 failure status
    task automatic test_v4_errors();
        // one byte that announces a 20-byte header
        pkt_bytes = '{8'h45};
        send_packet();
        // one byte with no header: icmp part too short
        pkt_bytes = '{8'h00};
        send_packet();
        // header cut short
        make_packet(1'b0, 4'd5, V4_REQUEST, 0, 1'b1);
        truncate_packet(12);
        send_packet();
        // icmp header cut short
        make_packet(1'b0, 4'd5, V4_REQUEST, 0, 1'b1);
        truncate_packet(24);
        send_packet();
        make_packet(1'b0, 4'd5, V4_REQUEST, 4, 1'b0);
        send_packet();
        // good checksum, type that is not echo
        make_packet(1'b0, 4'd5, 8'd3, 2, 1'b1);
        send_packet();
    endtask

    // ipv6 types, ipv4 type code rejected, short packet, extreme payload bytes
    task automatic test_ipv6();
        set_ip_mode(1'b1);
        make_packet(1'b1, 4'd0, V6_REQUEST, 2, 1'b1);
        pkt_bytes[8] = 8'h00;
        pkt_bytes[9] = 8'hff;
        send_packet();
        make_packet(1'b1, 4'd0, V6_REPLY, 1, 1'b1);
        send_packet();
        make_packet(1'b1, 4'd0, V4_REQUEST, 1, 1'b1);
        send_packet();
        make_packet(1'b1, 4'd0, V6_REPLY, 0, 1'b1);
        truncate_packet(7);
        send_packet();
    endtask

    // one long packet sent back to back: payload keeps flowing, length adds up
    task automatic test_long_packet();
        jitter_on = 1'b0;
        make_packet(1'b1, 4'd0, V6_REQUEST, 200, 1'b1);
        send_packet();
    endtask

    // random traffic in phases that alternate the ip mode
    task automatic test_random();
        int         ph;
        int         budget;
        int         kind;
        int         plen;
        int         pick;
        logic [3:0] ihl;
        logic [7:0] typ;
        bit         v6;
        for (ph = 0; ph < 8; ph++) begin
            v6 = ph[0];
            set_ip_mode(v6);
            // some phases without idling, none at all at the tail
            jitter_on = (ph < 6) && (ph != 3);
            budget = byte_total + 120;
            while (byte_total < budget) begin
                kind = $urandom_range(0, 99);
                if (kind < 85) begin
                    // mostly well-formed echo packets with random content
                    ihl  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'd5;
                    plen = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 300)
                                                        : $urandom_range(0, 40);
                    pick = $urandom_range(0, 9);
                    if (pick < 5)      typ = v6 ? V6_REQUEST : V4_REQUEST;
                    else if (pick < 9) typ = v6 ? V6_REPLY : V4_REPLY;
                    else               typ = 8'($urandom);
                    // with no ipv4 header the type byte sets the header length
                    if (!v6 && ihl == 0 && pick < 9) typ = V4_REPLY;
                    make_packet(v6, ihl, typ, plen, $urandom_range(0, 9) != 0);
                    // broken packets: cut off at a random point
                    if (kind >= 70) truncate_packet($urandom_range(1, pkt_bytes.size()));
                end else begin
                    // noise
                    pkt_bytes.delete();
                    repeat ($urandom_range(1, 30)) pkt_bytes.push_back(8'($urandom));
                end
                send_packet();
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_v4_echo();
        test_v4_errors();
        test_ipv6();
        test_long_packet();
        test_random();
        // drain, then keep watching for anything stray
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        mismatch_count += pending_results.size();
        $display("sent %0d packets (%0d bytes) in ipv4 and ipv6 modes, good, broken and noise",
                 pkt_count, byte_total);
        $display("checked %0d output requests, %0d mismatches", results_checked,
                 mismatch_count);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
